// File: rtl/sawe_pkg.sv
// Package for the selective-ack window engine.
// Holds the shared constants, item and command types and the sequencer states.
// It depends on nothing.
package sawe_pkg;

	localparam int SEQ_SLOTS   = 256;
	localparam int ACK_WINDOW  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] TOP_ACK_BIT = 32'h8000_0000;
	localparam logic [8:0]  SLOTS_FULL  = 9'd256;

	typedef enum logic {
		CMD_SEND = 1'b0,
		CMD_RECV = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  rcv_seq;
		logic [7:0]  peer_ack;
		logic [31:0] peer_ack_bits;
	} item_t;

	// Link between the front queue and the back sequencer.
	typedef struct packed {
		logic  avail;
		item_t item;
	} q_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEND,
		ST_WALK,
		ST_HEAD_RD,
		ST_HEAD,
		ST_HELD,
		ST_MARK,
		ST_DELIV,
		ST_DONE
	} state_t;

endpackage

// File: rtl/sawe_front.sv
// Front part of the selective-ack window engine: accepts input transactions
// and holds them in a short queue for the back sequencer.
// Depends on sawe_pkg.
module sawe_front #(
	parameter int QD = sawe_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sawe_pkg::item_t in_item,
	output sawe_pkg::q_out_t q_out,
	input  logic            q_pop
);
	import sawe_pkg::*;

	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	item_t          mem_q [QD];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;

	assign in_stall = (cnt_q == CW'(QD));
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && (cnt_q != '0);

	assign q_out.avail = (cnt_q != '0);
	assign q_out.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/sawe_back.sv
// Back part of the selective-ack window engine: a sequencer that carries out
// one queued transaction at a time and registers its result.
// Depends on sawe_pkg.
module sawe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sawe_pkg::q_out_t q_in,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       tx_seq,
	output logic [7:0]       hdr_ack,
	output logic [31:0]      hdr_ack_bits,
	output logic             tx_full,
	output logic             duplicate,
	output logic [8:0]       delivered_count,
	output logic [7:0]       rx_next_seq,
	output logic [8:0]       tx_pending,
	output logic [7:0]       tx_oldest
);
	import sawe_pkg::*;

	state_t state_q, state_d;

	// Slot flag memories, one registered read port each.
	logic        outst_mem [SEQ_SLOTS];
	logic        held_mem  [SEQ_SLOTS];
	logic        outst_rd_q, held_rd_q;
	logic [7:0]  outst_ra, held_ra, outst_wa, held_wa;
	logic        outst_we, outst_wd, held_we, held_wd, held_re, held_byp;
	logic [7:0]  clr_q;

	logic [7:0]  tx_head_q, tx_tail_q, rx_head_q, newest_q;
	logic [8:0]  tx_count_q, rx_count_q;
	logic [31:0] window_q;

	cmd_t        cmd_q;
	logic [7:0]  seq_q, cur_q, txseq_q;
	logic [31:0] bits_q;
	logic [5:0]  n_q;
	logic        full_q, dup_q;
	logic [8:0]  deliv_q;

	logic        out_valid_q;
	logic        ld_out;
	logic        take;

	logic        send_full;
	logic        walk_end, walk_stop;
	logic        head_end;
	logic        deliv_end;
	logic [7:0]  ahead, behind, back;
	logic [31:0] step_win, mark_win, mark_bit;
	logic [7:0]  step_new, mark_new;
	logic        mark_dup;

	assign send_full = (tx_count_q == SLOTS_FULL) || outst_rd_q;
	assign walk_end  = (n_q == 6'(ACK_WINDOW)) || (bits_q == '0);
	assign walk_stop = (cur_q == tx_head_q);
	assign head_end  = (tx_head_q == tx_tail_q) || outst_rd_q;
	assign deliv_end = (rx_count_q == '0) || !held_rd_q;

	// Ack window, first half: move forward on a newer sequence.
	assign ahead = seq_q - newest_q;
	always_comb begin
		step_win = window_q;
		step_new = newest_q;
		if (ahead >= 8'd1 && ahead <= 8'd127) begin
			step_win = (ahead >= 8'(ACK_WINDOW)) ? '0 : (window_q << ahead[4:0]);
			step_new = seq_q;
		end
	end

	// Second half: pick the bit, moving back when the sequence is too old.
	assign behind = newest_q - seq_q;
	assign back   = behind - 8'(ACK_WINDOW - 1);
	always_comb begin
		mark_win = window_q;
		mark_new = newest_q;
		mark_bit = 32'd1 << behind[4:0];
		if (behind >= 8'(ACK_WINDOW)) begin
			mark_win = (back >= 8'(ACK_WINDOW)) ? '0 : (window_q >> back[4:0]);
			mark_new = newest_q - back;
			mark_bit = TOP_ACK_BIT;
		end
	end
	assign mark_dup = |(mark_win & mark_bit);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == 8'hff) state_d = ST_IDLE;
			ST_IDLE:  if (q_in.avail) begin
				state_d = (q_in.item.cmd == CMD_SEND) ? ST_SEND : ST_WALK;
			end
			ST_SEND:    state_d = ST_DONE;
			ST_WALK:    if (walk_end || walk_stop) state_d = ST_HEAD_RD;
			ST_HEAD_RD: state_d = ST_HEAD;
			ST_HEAD:    if (head_end) state_d = ST_HELD;
			ST_HELD:    state_d = held_rd_q ? ST_DONE : ST_MARK;
			ST_MARK:    state_d = mark_dup ? ST_DONE : ST_DELIV;
			ST_DELIV:   if (deliv_end) state_d = ST_DONE;
			ST_DONE:    if (take) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	assign take = !out_valid_q || !out_stall;

	always_comb begin
		q_pop  = 1'b0;
		ld_out = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop  = q_in.avail;
			ST_DONE: ld_out = take;
			default: begin
				q_pop  = 1'b0;
				ld_out = 1'b0;
			end
		endcase
	end

	// Read addresses: prefetch the slot the next cycle looks at.
	always_comb begin
		outst_ra = tx_head_q;
		held_ra  = rx_head_q;
		held_re  = 1'b0;
		held_byp = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				outst_ra = (q_in.item.cmd == CMD_SEND) ? tx_tail_q : q_in.item.peer_ack;
				held_ra  = q_in.item.rcv_seq;
				held_re  = 1'b1;
			end
			ST_WALK:    outst_ra = cur_q - 8'd1;
			ST_HEAD_RD: outst_ra = tx_head_q;
			ST_HEAD:    outst_ra = tx_head_q + 8'd1;
			ST_MARK: begin
				held_ra  = rx_head_q;
				held_re  = 1'b1;
				held_byp = (seq_q == rx_head_q);
			end
			ST_DELIV: begin
				held_ra = rx_head_q + 8'd1;
				held_re = 1'b1;
			end
			default: ;
		endcase
	end

	// Write port controls: one slot per memory per cycle.
	always_comb begin
		outst_we = 1'b0;
		outst_wa = tx_tail_q;
		outst_wd = 1'b0;
		held_we  = 1'b0;
		held_wa  = rx_head_q;
		held_wd  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				outst_we = 1'b1;
				outst_wa = clr_q;
				held_we  = 1'b1;
				held_wa  = clr_q;
			end
			ST_SEND: if (!send_full) begin
				outst_we = 1'b1;
				outst_wd = 1'b1;
			end
			ST_WALK: if (!walk_end && bits_q[0] && outst_rd_q) begin
				outst_we = 1'b1;
				outst_wa = cur_q;
			end
			ST_MARK: if (!mark_dup) begin
				held_we = 1'b1;
				held_wa = seq_q;
				held_wd = 1'b1;
			end
			ST_DELIV: if (!deliv_end) begin
				held_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (outst_we) outst_mem[outst_wa] <= outst_wd;
		outst_rd_q <= outst_mem[outst_ra];
	end

	always_ff @(posedge clk) begin
		if (held_we) held_mem[held_wa] <= held_wd;
		if (held_re) held_rd_q <= held_byp || held_mem[held_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			tx_count_q  <= '0;
			rx_head_q   <= '0;
			rx_count_q  <= '0;
			newest_q    <= '0;
			window_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 8'd1;
				ST_SEND: if (!send_full) begin
					tx_count_q <= tx_count_q + 9'd1;
					tx_tail_q  <= tx_tail_q + 8'd1;
				end
				ST_WALK: if (!walk_end && bits_q[0] && outst_rd_q) begin
					if (tx_count_q != '0) tx_count_q <= tx_count_q - 9'd1;
				end
				ST_HEAD: if (!head_end) tx_head_q <= tx_head_q + 8'd1;
				ST_HELD: if (!held_rd_q) begin
					window_q <= step_win;
					newest_q <= step_new;
				end
				ST_MARK: begin
					newest_q <= mark_new;
					if (mark_dup) begin
						window_q <= mark_win;
					end else begin
						window_q   <= mark_win | mark_bit;
						rx_count_q <= rx_count_q + 9'd1;
					end
				end
				ST_DELIV: if (!deliv_end) begin
					rx_head_q  <= rx_head_q + 8'd1;
					rx_count_q <= rx_count_q - 9'd1;
				end
				default: ;
			endcase
		end
	end

	// Per-transaction working registers and the result register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= q_in.item.cmd;
				seq_q   <= q_in.item.rcv_seq;
				cur_q   <= q_in.item.peer_ack;
				bits_q  <= q_in.item.peer_ack_bits;
				n_q     <= '0;
				full_q  <= 1'b0;
				dup_q   <= 1'b0;
				txseq_q <= '0;
				deliv_q <= '0;
			end
			ST_SEND: begin
				full_q <= send_full;
				if (!send_full) txseq_q <= tx_tail_q;
			end
			ST_WALK: begin
				bits_q <= bits_q >> 1;
				cur_q  <= cur_q - 8'd1;
				n_q    <= n_q + 6'd1;
			end
			ST_HELD:  if (held_rd_q) dup_q <= 1'b1;
			ST_MARK:  dup_q <= mark_dup;
			ST_DELIV: if (!deliv_end) deliv_q <= deliv_q + 9'd1;
			default: ;
		endcase
		if (ld_out) begin
			tx_seq          <= txseq_q;
			hdr_ack         <= newest_q;
			hdr_ack_bits    <= window_q;
			tx_full         <= full_q;
			duplicate       <= dup_q;
			delivered_count <= deliv_q;
			rx_next_seq     <= rx_head_q;
			tx_pending      <= tx_count_q;
			tx_oldest       <= tx_head_q;
		end
	end

	assign out_valid = out_valid_q;

	a_tx_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		tx_count_q <= SLOTS_FULL)
		else $error("tx_count above slot count");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not raise valid");

	a_send_no_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && cmd_q == CMD_SEND) |-> !dup_q && deliv_q == '0)
		else $error("send transaction carries receive result");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE && q_in.avail)
		else $error("queue popped outside idle");

endmodule

// File: rtl/selective_ack_window_engine.sv
// Top level of the selective-ack window engine: front queue plus back sequencer.
// Depends on sawe_pkg, sawe_front and sawe_back.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  input   | in_valid / in_stall | command rcv_seq peer_ack peer_ack_bits
//  output  | out_valid/out_stall | tx_seq hdr_ack hdr_ack_bits tx_full duplicate
//          |                     | delivered_count rx_next_seq tx_pending tx_oldest
//
// A send transaction goes from the queue through the send and done states to
// the result register. A receive transaction walks the peer-ack bitfield (one
// bitfield position a cycle, at most 32), advances the oldest pointer and, unless
// it is a duplicate, marks the held flag and releases in-order slots, one a cycle.
// After reset a clearing pass over all 256 slots zeroes the slot flag memories
// before the first transaction is taken; pointers and counters clear at once.
// The front queue keeps accepting while the sequencer works or a result is
// stalled; in_stall rises only when the queue is full.
module selective_ack_window_engine #(
	parameter int QUEUE_DEPTH = sawe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rcv_seq,
	input  logic [7:0]  peer_ack,
	input  logic [31:0] peer_ack_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_seq,
	output logic [7:0]  hdr_ack,
	output logic [31:0] hdr_ack_bits,
	output logic        tx_full,
	output logic        duplicate,
	output logic [8:0]  delivered_count,
	output logic [7:0]  rx_next_seq,
	output logic [8:0]  tx_pending,
	output logic [7:0]  tx_oldest
);
	import sawe_pkg::*;

	item_t  in_item;
	q_out_t q_link;
	logic   q_pop;

	// Classify the transaction by its command bit.
	assign in_item.cmd           = command ? CMD_RECV : CMD_SEND;
	assign in_item.rcv_seq       = rcv_seq;
	assign in_item.peer_ack      = peer_ack;
	assign in_item.peer_ack_bits = peer_ack_bits;

	sawe_front #(.QD(QUEUE_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_out    (q_link),
		.q_pop    (q_pop)
	);

	sawe_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_in            (q_link),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tx_seq          (tx_seq),
		.hdr_ack         (hdr_ack),
		.hdr_ack_bits    (hdr_ack_bits),
		.tx_full         (tx_full),
		.duplicate       (duplicate),
		.delivered_count (delivered_count),
		.rx_next_seq     (rx_next_seq),
		.tx_pending      (tx_pending),
		.tx_oldest       (tx_oldest)
	);

endmodule
